// ===== rtl/tads_pkg.sv =====
package tads_pkg;

  // default line length of the text image
  localparam int MAX_WIDTH_DEF = 1024;

  // tallest frame the row counter supports
  localparam int MAX_HEIGHT = 1024;
  localparam int ROW_W      = 10;

  // field widths
  localparam int SIZE_W    = 11;
  localparam int ALPHA_W   = 8;
  localparam int RGB_W     = 24;
  localparam int ARGB_W    = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;

  // register reset values
  localparam logic [SIZE_W-1:0]  FRAME_WIDTH_RST  = 11'd1024;
  localparam logic [SIZE_W-1:0]  FRAME_HEIGHT_RST = 11'd16;
  localparam logic               OUTLINE_RST      = 1'b1;
  localparam logic [ALPHA_W-1:0] SHADOW_THR_RST   = 8'd100;
  localparam logic [ALPHA_W-1:0] TEXT_THR_RST     = 8'd70;
  localparam logic [ARGB_W-1:0]  SHADOW_COLOR_RST = 32'hff10_1010;
  localparam logic [RGB_W-1:0]   TEXT_RGB_RST     = 24'hff_ffff;

  typedef logic [ALPHA_W-1:0] alpha_t;
  typedef logic [ARGB_W-1:0]  argb_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_OUTLINE_EN   = 3'd2,
    REG_SHADOW_THR   = 3'd3,
    REG_TEXT_THR     = 3'd4,
    REG_SHADOW_COLOR = 3'd5,
    REG_TEXT_RGB     = 3'd6
  } reg_idx_t;

endpackage

// ===== rtl/tads_in_if.sv =====
interface tads_in_if;
  logic            valid;
  logic            ready;
  tads_pkg::alpha_t coverage;

  modport source (output valid, output coverage, input ready);
  modport sink   (input valid, input coverage, output ready);
endinterface

// ===== rtl/tads_out_if.sv =====
interface tads_out_if;
  logic            valid;
  logic            ready;
  tads_pkg::argb_t argb_pixel;
  logic            frame_end;

  modport source (output valid, output argb_pixel, output frame_end, input ready);
  modport sink   (input valid, input argb_pixel, input frame_end, output ready);
endinterface

// ===== rtl/tads_cfg_if.sv =====
interface tads_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [tads_pkg::CFG_IDX_W-1:0]     index;
  logic [tads_pkg::CFG_DAT_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/tads_ram.sv =====
module tads_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // registered read, old data on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

// ===== rtl/text_alpha_drop_shadow.sv =====
// a pixel word is registered and appears on pix_out in the cycle after it is taken on pix_in
// throughput: one pixel per cycle while pix_out is ready, set by one line-store read and one write per pixel
// the line store is a single-bit ram of MAX_WIDTH entries, read and written each pixel
// rst (synchronous) restores register defaults, clears counters and the output valid;
// pix_in and cfg are held off while rst is high; the line store is not cleared
module text_alpha_drop_shadow #(
  parameter int MAX_WIDTH = tads_pkg::MAX_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  tads_in_if.sink    pix_in,
  tads_out_if.source pix_out,
  tads_cfg_if.sink   cfg
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int SW   = $clog2(MAX_WIDTH + 1);
  localparam int CMPW = ((SW > tads_pkg::SIZE_W) ? SW : tads_pkg::SIZE_W) + 1;
  localparam int HW   = tads_pkg::SIZE_W + 1;

  // configuration registers
  logic [tads_pkg::SIZE_W-1:0]  frame_width;
  logic [tads_pkg::SIZE_W-1:0]  frame_height;
  logic                         outline_enable;
  tads_pkg::alpha_t             shadow_threshold;
  tads_pkg::alpha_t             text_threshold;
  tads_pkg::argb_t              shadow_color;
  logic [tads_pkg::RGB_W-1:0]   text_rgb;

  // counters
  logic [CW-1:0]                col;
  logic [CW-1:0]                col_next;
  logic [tads_pkg::ROW_W-1:0]   row;
  logic [tads_pkg::ROW_W-1:0]   row_next;

  // output word
  logic            out_valid;
  tads_pkg::argb_t argb;
  logic            frame_end;

  logic            in_fire;
  logic            diag_rd;
  logic            flag_wr;
  logic            shadow_sel;
  tads_pkg::argb_t pix;
  logic            last_col;
  logic            last_row;
  logic [CMPW-1:0] w_ext;
  logic [CMPW-1:0] w_eff;
  logic [HW-1:0]   h_ext;
  logic [HW-1:0]   h_eff;

  assign cfg.ready = !rst;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width      <= tads_pkg::FRAME_WIDTH_RST;
      frame_height     <= tads_pkg::FRAME_HEIGHT_RST;
      outline_enable   <= tads_pkg::OUTLINE_RST;
      shadow_threshold <= tads_pkg::SHADOW_THR_RST;
      text_threshold   <= tads_pkg::TEXT_THR_RST;
      shadow_color     <= tads_pkg::SHADOW_COLOR_RST;
      text_rgb         <= tads_pkg::TEXT_RGB_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        tads_pkg::REG_FRAME_WIDTH:  frame_width      <= cfg.data[tads_pkg::SIZE_W-1:0];
        tads_pkg::REG_FRAME_HEIGHT: frame_height     <= cfg.data[tads_pkg::SIZE_W-1:0];
        tads_pkg::REG_OUTLINE_EN:   outline_enable   <= cfg.data[0];
        tads_pkg::REG_SHADOW_THR:   shadow_threshold <= cfg.data[tads_pkg::ALPHA_W-1:0];
        tads_pkg::REG_TEXT_THR:     text_threshold   <= cfg.data[tads_pkg::ALPHA_W-1:0];
        tads_pkg::REG_SHADOW_COLOR: shadow_color     <= cfg.data[tads_pkg::ARGB_W-1:0];
        tads_pkg::REG_TEXT_RGB:     text_rgb         <= cfg.data[tads_pkg::RGB_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake: output register parts the two sides
  assign pix_in.ready = !rst && (!out_valid || pix_out.ready);
  assign in_fire      = pix_in.valid && pix_in.ready;

  // line store: flag of the row above, read and rewritten at the current column
  assign flag_wr = (pix_in.coverage > shadow_threshold);

  tads_ram #(
    .WIDTH (1),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk   (clk),
    .we    (in_fire),
    .waddr (col),
    .wdata (flag_wr),
    .re    (in_fire),
    .raddr (col),
    .rdata (diag_rd)
  );

  // effective frame size, zero acts as one, oversize clamps
  always_comb begin
    w_ext = CMPW'(frame_width);
    if (w_ext == '0) begin
      w_eff = CMPW'(1);
    end else if (w_ext > CMPW'(MAX_WIDTH)) begin
      w_eff = CMPW'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    h_ext = HW'(frame_height);
    if (h_ext == '0) begin
      h_eff = HW'(1);
    end else if (h_ext > HW'(tads_pkg::MAX_HEIGHT)) begin
      h_eff = HW'(tads_pkg::MAX_HEIGHT);
    end else begin
      h_eff = h_ext;
    end
  end

  assign last_col = (CMPW'(col) + CMPW'(1)) >= w_eff;
  assign last_row = (HW'(row) + HW'(1)) >= h_eff;

  // pixel colouring; ram output holds the diagonal flag of the previous pixel
  assign shadow_sel = (row != '0) && (col != '0) && diag_rd;

  always_comb begin
    if (!outline_enable || (pix_in.coverage > text_threshold)) begin
      pix = {pix_in.coverage, text_rgb};
    end else if (shadow_sel) begin
      pix = shadow_color;
    end else begin
      pix = '0;
    end
  end

  // counter next values
  always_comb begin
    col_next = col;
    row_next = row;
    if (last_col) begin
      col_next = '0;
      row_next = last_row ? '0 : row + tads_pkg::ROW_W'(1);
    end else begin
      col_next = col + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (in_fire) begin
      col <= col_next;
      row <= row_next;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (pix_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      argb      <= pix;
      frame_end <= last_col && last_row;
    end
  end

  assign pix_out.valid      = out_valid;
  assign pix_out.argb_pixel = argb;
  assign pix_out.frame_end  = frame_end;

  // end of frame wraps both counters
  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    in_fire && last_col && last_row |=> (col == '0) && (row == '0))
    else $error("counters did not wrap at end of frame");

  // every taken pixel shows up as a word, with its frame mark
  a_word_out: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> out_valid && (frame_end == $past(last_col && last_row)))
    else $error("output word missing or frame mark wrong");

  // column steps by one inside a row
  a_col_step: assert property (@(posedge clk) disable iff (rst)
    in_fire && !last_col |=> (col == $past(col) + CW'(1)) && (row == $past(row)))
    else $error("column counter did not advance");

endmodule

// ===== sim/text_alpha_drop_shadow_tb.sv =====
`timescale 1ns / 1ps

module text_alpha_drop_shadow_tb;

  localparam int LINE_LEN    = tads_pkg::MAX_WIDTH_DEF;
  localparam int HOLD_CYCLES = 200;
  localparam int TAIL_CYCLES = 8;
  localparam int TIMEOUT_NS  = 6_000_000;

  // index with no register behind it
  localparam logic [tads_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  typedef struct packed {
    tads_pkg::argb_t argb;
    logic            frame_end;
  } shaded_t;

  typedef struct packed {
    logic [tads_pkg::CFG_IDX_W-1:0] idx;
    logic [tads_pkg::CFG_DAT_W-1:0] data;
  } reg_write_t;

  logic clk;
  logic rst;

  tads_in_if  pix_in ();
  tads_out_if pix_out ();
  tads_cfg_if cfg ();

  text_alpha_drop_shadow #(
    .MAX_WIDTH(LINE_LEN)
  ) DUT (
    .clk    (clk),
    .rst    (rst),
    .pix_in (pix_in),
    .pix_out(pix_out),
    .cfg    (cfg)
  );

  // register mirror
  logic [tads_pkg::SIZE_W-1:0] cfg_width        = tads_pkg::FRAME_WIDTH_RST;
  logic [tads_pkg::SIZE_W-1:0] cfg_height       = tads_pkg::FRAME_HEIGHT_RST;
  logic                        cfg_outline      = tads_pkg::OUTLINE_RST;
  tads_pkg::alpha_t            cfg_shadow_thr   = tads_pkg::SHADOW_THR_RST;
  tads_pkg::alpha_t            cfg_text_thr     = tads_pkg::TEXT_THR_RST;
  tads_pkg::argb_t             cfg_shadow_color = tads_pkg::SHADOW_COLOR_RST;
  logic [tads_pkg::RGB_W-1:0]  cfg_text_rgb     = tads_pkg::TEXT_RGB_RST;

  // line store and raster position mirror
  bit line_flags [LINE_LEN];
  bit diag_flag = 1'b0;
  int col_pos   = 0;
  int row_pos   = 0;

  shaded_t    pending_pixels[$];
  reg_write_t reg_writes[$];

  int items_sent     = 0;
  int mismatch_count = 0;
  bit pix_offered    = 1'b0;
  bit in_gaps        = 1'b0;
  bit out_gaps       = 1'b0;
  bit hold_go        = 1'b0;
  bit out_hold       = 1'b0;

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  initial begin
    #(TIMEOUT_NS);
    $display("DONE: errors detected");
    $finish;
  end

  function automatic int clamp_dim(logic [tads_pkg::SIZE_W-1:0] v, int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic void apply_reg(logic [tads_pkg::CFG_IDX_W-1:0] idx,
                                    logic [tads_pkg::CFG_DAT_W-1:0] data);
    case (tads_pkg::reg_idx_t'(idx))
      tads_pkg::REG_FRAME_WIDTH:  cfg_width        = data[tads_pkg::SIZE_W-1:0];
      tads_pkg::REG_FRAME_HEIGHT: cfg_height       = data[tads_pkg::SIZE_W-1:0];
      tads_pkg::REG_OUTLINE_EN:   cfg_outline      = data[0];
      tads_pkg::REG_SHADOW_THR:   cfg_shadow_thr   = data[tads_pkg::ALPHA_W-1:0];
      tads_pkg::REG_TEXT_THR:     cfg_text_thr     = data[tads_pkg::ALPHA_W-1:0];
      tads_pkg::REG_SHADOW_COLOR: cfg_shadow_color = data[tads_pkg::ARGB_W-1:0];
      tads_pkg::REG_TEXT_RGB:     cfg_text_rgb     = data[tads_pkg::RGB_W-1:0];
      default: ;
    endcase
  endfunction

  // expected shaded pixel for one coverage value, advances the raster mirror
  function automatic void shade_pixel(tads_pkg::alpha_t cov);
    int              w;
    int              h;
    int              idx;
    tads_pkg::argb_t text_px;
    tads_pkg::argb_t px;
    bit              above;
    bit              last_col;
    bit              last_row;
    w = clamp_dim(cfg_width, LINE_LEN);
    h = clamp_dim(cfg_height, tads_pkg::MAX_HEIGHT);
    idx = (col_pos < LINE_LEN) ? col_pos : LINE_LEN - 1;
    text_px = {cov, cfg_text_rgb};
    if (!cfg_outline || cov > cfg_text_thr) px = text_px;
    else if (row_pos > 0 && col_pos > 0 && diag_flag) px = cfg_shadow_color;
    else px = '0;
    // previous row flag moves to the diagonal, current flag goes into the store
    above = line_flags[idx];
    line_flags[idx] = (cov > cfg_shadow_thr);
    diag_flag = above;
    last_col = (col_pos + 1 >= w);
    last_row = (row_pos + 1 >= h);
    if (last_col) begin
      col_pos = 0;
      diag_flag = 1'b0;
      row_pos = last_row ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
    pending_pixels.push_back('{argb: px, frame_end: last_col && last_row});
  endfunction

  // coverage values biased toward the thresholds and the extremes
  function automatic tads_pkg::alpha_t pick_coverage();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hff;
      2: return cfg_text_thr;
      3: return cfg_text_thr + 8'd1;
      4: return cfg_shadow_thr;
      5: return cfg_shadow_thr + 8'd1;
      default: return tads_pkg::alpha_t'($urandom);
    endcase
  endfunction

  function automatic void queue_reg(logic [tads_pkg::CFG_IDX_W-1:0] idx,
                                    logic [tads_pkg::CFG_DAT_W-1:0] data);
    reg_writes.push_back('{idx: idx, data: data});
  endfunction

  // one coverage word through the input handshake
  task automatic send_pixel(input tads_pkg::alpha_t cov);
    int gap;
    gap = in_gaps ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      if (pix_offered) begin
        pix_in.valid <= 1'b0;
        pix_offered = 1'b0;
      end
      repeat (gap) @(posedge clk);
    end
    pix_in.valid    <= 1'b1;
    pix_in.coverage <= cov;
    pix_offered = 1'b1;
    @(posedge clk);
    while (!pix_in.ready) @(posedge clk);
    shade_pixel(cov);
    items_sent++;
  endtask

  // stop offering and wait for every expected word
  task automatic drain_pixels();
    if (pix_offered) begin
      pix_in.valid <= 1'b0;
      pix_offered = 1'b0;
    end
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  // flush queued register writes back to back, block must be idle
  task automatic program_regs();
    reg_write_t wr;
    while (reg_writes.size() != 0) begin
      wr = reg_writes.pop_front();
      cfg.valid <= 1'b1;
      cfg.index <= wr.idx;
      cfg.data  <= wr.data;
      @(posedge clk);
      while (!cfg.ready) @(posedge clk);
      apply_reg(wr.idx, wr.data);
    end
    cfg.valid <= 1'b0;
  endtask

  task automatic finish_frame();
    while (col_pos != 0 || row_pos != 0) send_pixel(pick_coverage());
  endtask

  // output side: check each word, then decide ready for the next cycle
  initial begin
    int sink_wait;
    shaded_t want;
    sink_wait = 0;
    pix_out.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && pix_out.valid && pix_out.ready) begin
        if (pending_pixels.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected word: argb %h frame_end %b", pix_out.argb_pixel,
                     pix_out.frame_end);
        end else begin
          want = pending_pixels.pop_front();
          if (pix_out.argb_pixel !== want.argb || pix_out.frame_end !== want.frame_end) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: expected argb %h frame_end %b, got argb %h frame_end %b",
                       want.argb, want.frame_end, pix_out.argb_pixel, pix_out.frame_end);
          end
        end
        sink_wait = out_gaps ? $urandom_range(0, 10) : 0;
      end
      if (rst || out_hold) begin
        pix_out.ready <= 1'b0;
      end else if (sink_wait > 0) begin
        pix_out.ready <= 1'b0;
        sink_wait--;
      end else begin
        pix_out.ready <= 1'b1;
      end
    end
  end

  // long receiver hold-off, counted here once requested
  initial begin
    forever begin
      wait (hold_go);
      out_hold = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      out_hold = 1'b0;
      hold_go = 1'b0;
    end
  end

  // reset register values, fills every line store entry on the first row
  task automatic test_reset_defaults();
    in_gaps = 1'b0;
    out_gaps = 1'b1;
    repeat (LINE_LEN + 40) send_pixel(pick_coverage());
    drain_pixels();
  endtask

  // edges of both thresholds, corner pixels, plain mode and size clamping
  task automatic test_directed_cases();
    tads_pkg::alpha_t frame_pat [12];
    frame_pat = '{8'd255, 8'd101, 8'd100, 8'd0,
                  8'd0,   8'd0,   8'd70,  8'd0,
                  8'd71,  8'd0,   8'd0,   8'd255};
    in_gaps = 1'b1;
    out_gaps = 1'b1;
    queue_reg(tads_pkg::REG_FRAME_WIDTH, 32'd4);
    queue_reg(tads_pkg::REG_FRAME_HEIGHT, 32'd3);
    queue_reg(tads_pkg::REG_OUTLINE_EN, 32'd1);
    queue_reg(tads_pkg::REG_SHADOW_THR, 32'd100);
    queue_reg(tads_pkg::REG_TEXT_THR, 32'd70);
    queue_reg(tads_pkg::REG_SHADOW_COLOR, $urandom);
    queue_reg(tads_pkg::REG_TEXT_RGB, $urandom);
    program_regs();
    finish_frame();
    foreach (frame_pat[i]) send_pixel(frame_pat[i]);
    // plain mode ignores the thresholds
    drain_pixels();
    queue_reg(tads_pkg::REG_OUTLINE_EN, 32'hffff_fffe);
    program_regs();
    send_pixel(8'd255);
    send_pixel(8'd0);
    send_pixel(8'd70);
    send_pixel(8'd128);
    // zero sizes act as one, every word ends a frame
    drain_pixels();
    queue_reg(tads_pkg::REG_OUTLINE_EN, 32'd1);
    queue_reg(tads_pkg::REG_FRAME_WIDTH, 32'hffff_f800);
    queue_reg(tads_pkg::REG_FRAME_HEIGHT, 32'd0);
    program_regs();
    send_pixel(8'd255);
    send_pixel(8'd0);
    // oversized sizes clamp, spare index is ignored
    drain_pixels();
    queue_reg(tads_pkg::REG_FRAME_WIDTH, 32'd2047);
    queue_reg(tads_pkg::REG_FRAME_HEIGHT, 32'd2047);
    queue_reg(REG_SPARE, $urandom);
    program_regs();
    send_pixel(8'd71);
    send_pixel(8'd0);
    send_pixel(8'd255);
    drain_pixels();
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_output_stall();
    in_gaps = 1'b0;
    out_gaps = 1'b0;
    hold_go = 1'b1;
    repeat (80) send_pixel(pick_coverage());
    drain_pixels();
  endtask

  // sender waits for every word before going on
  task automatic test_sender_pause();
    in_gaps = 1'b1;
    out_gaps = 1'b1;
    repeat (20) send_pixel(pick_coverage());
    drain_pixels();
    repeat (20) send_pixel(pick_coverage());
    drain_pixels();
  endtask

  // random settings, mostly whole small frames, some large partial bursts
  task automatic test_random_frames(input int n_items);
    int                          start_count;
    int                          n_frames;
    logic [tads_pkg::SIZE_W-1:0] w_val;
    logic [tads_pkg::SIZE_W-1:0] h_val;
    tads_pkg::alpha_t            thr;
    while (items_sent - start_count < n_items || start_count == 0) begin
      if (start_count == 0) start_count = items_sent;
      drain_pixels();
      in_gaps = $urandom_range(0, 1);
      out_gaps = $urandom_range(0, 1);
      // frame size
      case ($urandom_range(0, 9))
        0: w_val = 11'd0;
        1: w_val = 11'd1;
        2: w_val = 11'd1024;
        3: w_val = $urandom_range(1025, 2047);
        default: w_val = $urandom_range(1, 12);
      endcase
      case ($urandom_range(0, 9))
        0: h_val = 11'd0;
        1: h_val = 11'd1;
        2: h_val = 11'd1024;
        3: h_val = $urandom_range(1025, 2047);
        default: h_val = $urandom_range(1, 6);
      endcase
      if ($urandom_range(0, 3) != 0)
        queue_reg(tads_pkg::REG_FRAME_WIDTH, ($urandom & 32'hffff_f800) | w_val);
      if ($urandom_range(0, 3) != 0)
        queue_reg(tads_pkg::REG_FRAME_HEIGHT, ($urandom & 32'hffff_f800) | h_val);
      // mode and colors
      if ($urandom_range(0, 1))
        queue_reg(tads_pkg::REG_OUTLINE_EN,
                  ($urandom & 32'hffff_fffe) | ($urandom_range(0, 9) < 7));
      if ($urandom_range(0, 1)) begin
        thr = ($urandom_range(0, 4) == 0) ? ($urandom_range(0, 1) ? 8'hff : 8'h00)
                                         : tads_pkg::alpha_t'($urandom);
        queue_reg(tads_pkg::REG_SHADOW_THR, ($urandom & 32'hffff_ff00) | thr);
      end
      if ($urandom_range(0, 1)) begin
        thr = ($urandom_range(0, 4) == 0) ? ($urandom_range(0, 1) ? 8'hff : 8'h00)
                                         : tads_pkg::alpha_t'($urandom);
        queue_reg(tads_pkg::REG_TEXT_THR, ($urandom & 32'hffff_ff00) | thr);
      end
      if ($urandom_range(0, 1)) queue_reg(tads_pkg::REG_SHADOW_COLOR, $urandom);
      if ($urandom_range(0, 1)) queue_reg(tads_pkg::REG_TEXT_RGB, $urandom);
      if ($urandom_range(0, 9) == 0) queue_reg(REG_SPARE, $urandom);
      program_regs();
      // small frames run whole, large ones get a partial burst
      if (clamp_dim(cfg_width, LINE_LEN) * clamp_dim(cfg_height, tads_pkg::MAX_HEIGHT) <= 96 &&
          $urandom_range(0, 7) != 0) begin
        finish_frame();
        n_frames = $urandom_range(1, 3);
        repeat (n_frames) begin
          send_pixel(pick_coverage());
          finish_frame();
        end
      end else begin
        repeat ($urandom_range(10, 120)) send_pixel(pick_coverage());
      end
    end
    drain_pixels();
  endtask

  // test sequence
  initial begin
    rst             <= 1'b1;
    pix_in.valid    <= 1'b0;
    pix_in.coverage <= '0;
    cfg.valid       <= 1'b0;
    cfg.index       <= '0;
    cfg.data        <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_directed_cases();
    test_output_stall();
    test_sender_pause();
    test_random_frames(650);
    drain_pixels();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_pixels.size() != 0) mismatch_count++;
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/tads_pkg.sv
rtl/tads_in_if.sv
rtl/tads_out_if.sv
rtl/tads_cfg_if.sv
rtl/tads_ram.sv
rtl/text_alpha_drop_shadow.sv
sim/text_alpha_drop_shadow_tb.sv
